// File: src/mcp_pkg.sv
// Shared types, codes and widths for the multichannel convolution pixel engine.
`timescale 1ns / 1ps

package mcp_pkg;

  // Port field widths
  localparam int OP_W       = 2;
  localparam int ADDR_W     = 17;
  localparam int DATA_W     = 32;
  localparam int CHAN_W     = 5;
  localparam int POS_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // Width of an unreduced store address; every in-map feature address and
  // every weight address of a legal register setting fits here.
  localparam int ADDR_FULL_W = 20;

  // Bias store
  localparam int BIAS_WORDS = 32;

  typedef enum logic [OP_W-1:0] {
    OP_FEATURE = 2'd0,
    OP_WEIGHT  = 2'd1,
    OP_BIAS    = 2'd2,
    OP_COMPUTE = 2'd3
  } mcp_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_CHANNELS   = 3'd0,
    REG_OUT_CHANNELS  = 3'd1,
    REG_KERNEL_WIDTH  = 3'd2,
    REG_KERNEL_HEIGHT = 3'd3,
    REG_MAP_WIDTH     = 3'd4,
    REG_MAP_HEIGHT    = 3'd5,
    REG_STEP_SIZE     = 3'd6,
    REG_PAD_AMOUNT    = 3'd7
  } mcp_reg_t;

  // Sideband that travels with each address through the reduction pipe
  typedef struct packed {
    logic              tv;    // tap of a compute item
    logic              fwr;   // feature store write
    logic              wwr;   // weight store write
    logic              zero;  // tap outside the map or empty sum
    logic              last;  // final tap of the item
    logic [DATA_W-1:0] data;  // write data
  } mcp_tag_t;

  // Number of conditional-subtract stages needed to reduce an address
  function automatic int mcp_red_stages(input int depth);
    int dw;
    dw = $clog2(depth);
    return (ADDR_FULL_W > dw) ? (ADDR_FULL_W - dw + 1) : 1;
  endfunction

endpackage

// File: src/mcp_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module mcp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/mcp_modred.sv
// Pipelined reduction of an address modulo a fixed store depth.
`timescale 1ns / 1ps

module mcp_modred #(
  parameter int DEPTH  = 131072,
  parameter int IW     = 20,
  parameter int STAGES = 4
) (
  input  logic                     clk,
  input  logic [IW-1:0]            x_in,
  output logic [$clog2(DEPTH)-1:0] x_out
);

  localparam int AW = $clog2(DEPTH);

  logic [IW-1:0] stg [STAGES];

  // Restoring reduction: stage s subtracts DEPTH shifted by the remaining weight
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam logic [63:0] SUB = 64'(DEPTH) << (STAGES - 1 - s);
    logic [IW-1:0] prev;

    if (s == 0) begin : g_first
      assign prev = x_in;
    end else begin : g_next
      assign prev = stg[s-1];
    end

    always_ff @(posedge clk) begin
      stg[s] <= (64'(prev) >= SUB) ? (prev - SUB[IW-1:0]) : prev;
    end
  end

  assign x_out = stg[STAGES-1][AW-1:0];

endmodule

// File: src/multichannel_conv2d_pixel.sv
// Top level of the multichannel 2-D convolution engine, one output pixel per item.
`timescale 1ns / 1ps

// Load items (feature, weight, bias words) are taken one per clock while busy
// is low and never raise busy; feature and weight writes pass through the
// address reduction pipe to their stores, always ahead of any later compute. A
// compute item raises busy and walks every tap of its window, one
// multiply-accumulate per clock through the feature and weight memories: the
// setup states, then channels * kernel_height * kernel_width taps (at least 1),
// the address reduction pipe (of depth 4 for stores of 128K words), the store
// read, product, sum and output registers, then the done strobe. busy drops the
// cycle after done. done is high for exactly one cycle with out_value; the
// receiver cannot stall it, so it must take the value then. A compute for a
// channel at or above out_channels holds busy for one cycle and gives no result.
module multichannel_conv2d_pixel #(
  parameter int FEATURE_WORDS   = 131072,
  parameter int WEIGHT_WORDS    = 131072,
  parameter int MAX_IN_CHANNELS = 32,
  parameter int MAX_KERNEL_X    = 10,
  parameter int MAX_KERNEL_Y    = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [mcp_pkg::OP_W-1:0]             op,
  input  logic [mcp_pkg::ADDR_W-1:0]           addr,
  input  logic signed [mcp_pkg::DATA_W-1:0]    wdata,
  input  logic [mcp_pkg::CHAN_W-1:0]           out_chan,
  input  logic [mcp_pkg::POS_W-1:0]            out_row,
  input  logic [mcp_pkg::POS_W-1:0]            out_col,
  input  logic                                 cfg_we,
  input  logic [mcp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mcp_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                 done,
  output logic signed [mcp_pkg::DATA_W-1:0]    out_value
);

  import mcp_pkg::*;

  localparam int FAW    = $clog2(FEATURE_WORDS);
  localparam int WAW    = $clog2(WEIGHT_WORDS);
  localparam int FSTG   = mcp_red_stages(FEATURE_WORDS);
  localparam int WSTG   = mcp_red_stages(WEIGHT_WORDS);
  localparam int STAGES = (FSTG > WSTG) ? FSTG : WSTG;
  localparam int BAW    = $clog2(BIAS_WORDS);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SETUP1 = 6'b000010,
    S_SETUP2 = 6'b000100,
    S_SETUP3 = 6'b001000,
    S_RUN    = 6'b010000,
    S_WAIT   = 6'b100000
  } mcp_state_t;

  mcp_state_t state, state_next;

  // Configuration registers
  logic [5:0] in_channels, out_channels;
  logic [3:0] kernel_width, kernel_height;
  logic [6:0] map_width, map_height;
  logic [3:0] step_size, pad_amount;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_channels   <= 6'd1;
      out_channels  <= 6'd1;
      kernel_width  <= 4'd3;
      kernel_height <= 4'd3;
      map_width     <= 7'd8;
      map_height    <= 7'd8;
      step_size     <= 4'd1;
      pad_amount    <= 4'd0;
    end else if (cfg_we) begin
      unique case (mcp_reg_t'(cfg_index))
        REG_IN_CHANNELS:   in_channels   <= cfg_data[5:0];
        REG_OUT_CHANNELS:  out_channels  <= cfg_data[5:0];
        REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[3:0];
        REG_KERNEL_HEIGHT: kernel_height <= cfg_data[3:0];
        REG_MAP_WIDTH:     map_width     <= cfg_data[6:0];
        REG_MAP_HEIGHT:    map_height    <= cfg_data[6:0];
        REG_STEP_SIZE:     step_size     <= cfg_data[3:0];
        REG_PAD_AMOUNT:    pad_amount    <= cfg_data[3:0];
      endcase
    end
  end

  // Effective sizes, saturated at the build limits
  logic [5:0] nch_eff;
  logic [3:0] kw_eff, kh_eff;

  assign nch_eff = (32'(in_channels) > MAX_IN_CHANNELS) ? 6'(MAX_IN_CHANNELS) : in_channels;
  assign kw_eff  = (32'(kernel_width) > MAX_KERNEL_X) ? 4'(MAX_KERNEL_X) : kernel_width;
  assign kh_eff  = (32'(kernel_height) > MAX_KERNEL_Y) ? 4'(MAX_KERNEL_Y) : kernel_height;

  logic accept;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Compute item and window setup
  logic [CHAN_W-1:0]  chan_q;
  logic [POS_W-1:0]   row_q, col_q;
  logic [5:0]         nch_q;
  logic [3:0]         kw_q, kh_q;
  logic               empty_q;
  logic signed [11:0] ox_q, oy_q;
  logic [7:0]         kk_q;
  logic [13:0]        plane_q, nk_q;
  logic signed [18:0] oyw_q;
  logic [9:0]         col_sc, row_sc;

  assign col_sc = 10'(col_q) * 10'(step_size);
  assign row_sc = 10'(row_q) * 10'(step_size);

  // Window walk
  logic [3:0]         j, i;
  logic [5:0]         c;
  logic signed [11:0] xi, yi;
  logic signed [21:0] ch_fp, row_fp, fp;
  logic [18:0]        wp;
  logic               in_map, row_end, ch_end, all_end;
  logic signed [21:0] row_fp_inc, ch_fp_inc;

  assign in_map  = !xi[11] && (xi < $signed({5'b0, map_width})) &&
                   !yi[11] && (yi < $signed({5'b0, map_height}));
  assign row_end = (j == kw_q - 4'd1);
  assign ch_end  = row_end && (i == kh_q - 4'd1);
  assign all_end = empty_q || (ch_end && (c == nch_q - 6'd1));

  assign row_fp_inc = row_fp + $signed({15'b0, map_width});
  assign ch_fp_inc  = ch_fp + $signed({8'b0, plane_q});

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (mcp_op_t'(op) == OP_COMPUTE)) begin
          state_next = S_SETUP1;
        end
      end
      S_SETUP1: begin
        if ({1'b0, chan_q} >= out_channels) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_SETUP2;
        end
      end
      S_SETUP2: state_next = S_SETUP3;
      S_SETUP3: state_next = S_RUN;
      S_RUN: begin
        if (all_end) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Setup arithmetic and walk counters
  always_ff @(posedge clk) begin
    if (accept && (mcp_op_t'(op) == OP_COMPUTE)) begin
      chan_q <= out_chan;
      row_q  <= out_row;
      col_q  <= out_col;
    end

    if (state == S_SETUP1) begin
      nch_q   <= nch_eff;
      kw_q    <= kw_eff;
      kh_q    <= kh_eff;
      empty_q <= (nch_eff == 6'd0) || (kw_eff == 4'd0) || (kh_eff == 4'd0);
      ox_q    <= $signed({2'b0, col_sc}) - $signed({8'b0, pad_amount});
      oy_q    <= $signed({2'b0, row_sc}) - $signed({8'b0, pad_amount});
      kk_q    <= 8'(kw_eff) * 8'(kh_eff);
      plane_q <= 14'(map_width) * 14'(map_height);
    end

    if (state == S_SETUP2) begin
      nk_q  <= 14'(nch_q) * 14'(kk_q);
      oyw_q <= 19'(oy_q) * 19'($signed({1'b0, map_width}));
    end

    if (state == S_SETUP3) begin
      wp     <= 19'(chan_q) * 19'(nk_q);
      ch_fp  <= 22'(oyw_q) + 22'(ox_q);
      row_fp <= 22'(oyw_q) + 22'(ox_q);
      fp     <= 22'(oyw_q) + 22'(ox_q);
      xi     <= ox_q;
      yi     <= oy_q;
      j      <= 4'd0;
      i      <= 4'd0;
      c      <= 6'd0;
    end

    // One tap per cycle: column, then row, then channel
    if (state == S_RUN) begin
      wp <= wp + 19'd1;
      if (!row_end) begin
        j  <= j + 4'd1;
        xi <= xi + 12'sd1;
        fp <= fp + 22'sd1;
      end else if (!ch_end) begin
        j      <= 4'd0;
        i      <= i + 4'd1;
        xi     <= ox_q;
        yi     <= yi + 12'sd1;
        row_fp <= row_fp_inc;
        fp     <= row_fp_inc;
      end else begin
        j      <= 4'd0;
        i      <= 4'd0;
        c      <= c + 6'd1;
        xi     <= ox_q;
        yi     <= oy_q;
        ch_fp  <= ch_fp_inc;
        row_fp <= ch_fp_inc;
        fp     <= ch_fp_inc;
      end
    end
  end

  // Requests into the reduction pipe: compute taps or store writes
  mcp_tag_t               req_tag;
  logic [ADDR_FULL_W-1:0] f_full, w_full;

  always_comb begin
    req_tag = '0;
    f_full  = fp[ADDR_FULL_W-1:0];
    w_full  = ADDR_FULL_W'(wp);
    if (state == S_RUN) begin
      req_tag.tv   = 1'b1;
      req_tag.zero = empty_q || !in_map;
      req_tag.last = all_end;
    end else if (accept) begin
      case (mcp_op_t'(op))
        OP_FEATURE: begin
          req_tag.fwr  = 1'b1;
          req_tag.data = wdata;
          f_full       = ADDR_FULL_W'(addr);
        end
        OP_WEIGHT: begin
          req_tag.wwr  = 1'b1;
          req_tag.data = wdata;
          w_full       = ADDR_FULL_W'(addr);
        end
        default: ;
      endcase
    end
  end

  logic [FAW-1:0] f_idx;
  logic [WAW-1:0] w_idx;

  mcp_modred #(
    .DEPTH  (FEATURE_WORDS),
    .IW     (ADDR_FULL_W),
    .STAGES (STAGES)
  ) u_fred (
    .clk   (clk),
    .x_in  (f_full),
    .x_out (f_idx)
  );

  mcp_modred #(
    .DEPTH  (WEIGHT_WORDS),
    .IW     (ADDR_FULL_W),
    .STAGES (STAGES)
  ) u_wred (
    .clk   (clk),
    .x_in  (w_full),
    .x_out (w_idx)
  );

  // Sideband pipe matching the reduction depth, then the memory read
  mcp_tag_t tag_pipe [STAGES];
  mcp_tag_t mem_tag, tag_d;

  assign mem_tag = tag_pipe[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < STAGES; s++) begin
        tag_pipe[s] <= '0;
      end
      tag_d <= '0;
    end else begin
      tag_pipe[0] <= req_tag;
      for (int s = 1; s < STAGES; s++) begin
        tag_pipe[s] <= tag_pipe[s-1];
      end
      tag_d <= mem_tag;
    end
  end

  // Stores
  logic [DATA_W-1:0] f_rd, w_rd, bias_rd;
  logic              bias_we;

  assign bias_we = accept && (mcp_op_t'(op) == OP_BIAS);

  mcp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (FEATURE_WORDS)
  ) u_feature_store (
    .clk   (clk),
    .we    (mem_tag.fwr),
    .waddr (f_idx),
    .wdata (mem_tag.data),
    .re    (mem_tag.tv),
    .raddr (f_idx),
    .rdata (f_rd)
  );

  mcp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WEIGHT_WORDS)
  ) u_weight_store (
    .clk   (clk),
    .we    (mem_tag.wwr),
    .waddr (w_idx),
    .wdata (mem_tag.data),
    .re    (mem_tag.tv),
    .raddr (w_idx),
    .rdata (w_rd)
  );

  mcp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BIAS_WORDS)
  ) u_bias_store (
    .clk   (clk),
    .we    (bias_we),
    .waddr (addr[BAW-1:0]),
    .wdata (wdata),
    .re    (state == S_SETUP1),
    .raddr (chan_q[BAW-1:0]),
    .rdata (bias_rd)
  );

  // Multiply, accumulate, add bias
  logic [DATA_W-1:0] prod, acc, fin_sum;
  logic              prod_v, prod_last, fin_v;

  // Off-map taps and empty sums contribute nothing, whatever the stores hold
  always_ff @(posedge clk) begin
    prod      <= tag_d.zero ? '0 : (f_rd * w_rd);
    fin_sum   <= acc + prod;
    out_value <= fin_sum + bias_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v    <= 1'b0;
      prod_last <= 1'b0;
      fin_v     <= 1'b0;
      done      <= 1'b0;
      acc       <= '0;
    end else begin
      prod_v    <= tag_d.tv;
      prod_last <= tag_d.last;
      fin_v     <= prod_v && prod_last;
      done      <= fin_v;
      if (prod_v) begin
        acc <= prod_last ? '0 : (acc + prod);
      end
    end
  end

endmodule

// File: src/mcp_checker.sv
// Port-level checks on the convolution engine and their bind to the top level.
`timescale 1ns / 1ps

module mcp_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic [mcp_pkg::OP_W-1:0] op,
  input logic                     done
);

  import mcp_pkg::*;

  // A compute item always raises busy
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == OP_COMPUTE)) |=> busy)
    else $error("compute item did not raise busy");

  // Load items stream without stalling the port
  a_load_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op != OP_COMPUTE)) |=> !busy)
    else $error("load item raised busy");

  // A result only appears while a compute item is in flight
  a_done_in_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a compute");

  // The engine is free right after its result
  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> (!busy && !done))
    else $error("engine not released after result");

endmodule

bind multichannel_conv2d_pixel mcp_checker u_mcp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .op    (op),
  .done  (done)
);

// File: tb/multichannel_conv2d_pixel_test.sv
// Self-checking testbench for the multichannel 2-D convolution pixel engine.
`timescale 1ns / 1ps

module multichannel_conv2d_pixel_test;
  import mcp_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 11;
  localparam int FEATURE_WORDS   = 131072;
  localparam int WEIGHT_WORDS    = 131072;
  localparam int MAX_IN_CHANNELS = 32;
  localparam int MAX_KERNEL_X    = 10;
  localparam int MAX_KERNEL_Y    = 10;
  localparam int CHAN_COUNT      = 1 << CHAN_W;
  localparam int POS_MAX         = (1 << POS_W) - 1;
  localparam int IDLE_PCT        = 38;
  localparam int SETTLE_CYCLES   = 16;    // rejected compute holds busy one cycle
  localparam int DRAIN_CYCLES    = 3300;  // longest compute: 3200 taps plus pipeline
  localparam int STALL_LIMIT     = 20000;
  localparam int REPORT_LIMIT    = 10;
  localparam int N_PROBES        = 19;

  // One item as it goes onto the ports
  typedef struct packed {
    mcp_op_t             op;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   wdata;
    logic [CHAN_W-1:0]   chan;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
  } job_t;

  // Directed row: item plus an optional hand-computed pixel value
  typedef struct packed {
    mcp_op_t             op;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   wdata;
    logic [CHAN_W-1:0]   chan;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic                typed;
    logic [DATA_W-1:0]   want;
  } probe_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [OP_W-1:0]       op;
  logic [ADDR_W-1:0]     addr;
  logic signed [DATA_W-1:0] wdata;
  logic [CHAN_W-1:0]     out_chan;
  logic [POS_W-1:0]      out_row;
  logic [POS_W-1:0]      out_col;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  done;
  logic signed [DATA_W-1:0] out_value;

  // Shadow copy of the stores and registers
  bit [DATA_W-1:0] feat_mem   [FEATURE_WORDS];
  bit              feat_known [FEATURE_WORDS];
  bit [DATA_W-1:0] wgt_mem    [WEIGHT_WORDS];
  bit              wgt_known  [WEIGHT_WORDS];
  bit [DATA_W-1:0] bias_mem   [BIAS_WORDS];
  bit              bias_known [BIAS_WORDS];
  logic [5:0] cfg_in   = 6'd1;
  logic [5:0] cfg_out  = 6'd1;
  logic [3:0] cfg_kw   = 4'd3;
  logic [3:0] cfg_kh   = 4'd3;
  logic [6:0] cfg_mw   = 7'd8;
  logic [6:0] cfg_mh   = 7'd8;
  logic [3:0] cfg_step = 4'd1;
  logic [3:0] cfg_pad  = 4'd0;

  int unsigned       feat_gaps [$];
  int unsigned       wgt_gaps [$];
  logic [DATA_W-1:0] pixels_due [$];
  logic [DATA_W-1:0] want_value;
  int                fails = 0;
  int                stall = 0;
  int                idle_pct = IDLE_PCT;
  probe_t            probes [N_PROBES];

  multichannel_conv2d_pixel #(
    .FEATURE_WORDS  (FEATURE_WORDS),
    .WEIGHT_WORDS   (WEIGHT_WORDS),
    .MAX_IN_CHANNELS(MAX_IN_CHANNELS),
    .MAX_KERNEL_X   (MAX_KERNEL_X),
    .MAX_KERNEL_Y   (MAX_KERNEL_Y)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .op       (op),
    .addr     (addr),
    .wdata    (wdata),
    .out_chan (out_chan),
    .out_row  (out_row),
    .out_col  (out_col),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .done     (done),
    .out_value(out_value)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Window sum plus bias; also lists store entries the window reads unwritten
  function automatic logic [DATA_W-1:0] pixel_value(input logic [CHAN_W-1:0] ch,
                                                    input logic [POS_W-1:0] row,
                                                    input logic [POS_W-1:0] col);
    longint nch, kw, kh, mw, mh, ox, oy, xi, yi, wbase, fa, wa, c, i, j;
    logic [DATA_W-1:0] acc, f;
    nch = (cfg_in > MAX_IN_CHANNELS) ? MAX_IN_CHANNELS : cfg_in;
    kw  = (cfg_kw > MAX_KERNEL_X) ? MAX_KERNEL_X : cfg_kw;
    kh  = (cfg_kh > MAX_KERNEL_Y) ? MAX_KERNEL_Y : cfg_kh;
    mw  = cfg_mw;
    mh  = cfg_mh;
    ox  = longint'(col) * longint'(cfg_step) - longint'(cfg_pad);
    oy  = longint'(row) * longint'(cfg_step) - longint'(cfg_pad);
    wbase = longint'(ch) * nch * kw * kh;
    acc = '0;
    for (c = 0; c < nch; c++) begin
      for (i = 0; i < kh; i++) begin
        for (j = 0; j < kw; j++) begin
          xi = ox + j;
          yi = oy + i;
          wa = (wbase + c * kh * kw + i * kw + j) % WEIGHT_WORDS;
          if (!wgt_known[wa]) wgt_gaps.push_back(wa);
          f = '0;
          // taps off the map contribute zero
          if (xi >= 0 && xi < mw && yi >= 0 && yi < mh) begin
            fa = (c * mw * mh + yi * mw + xi) % FEATURE_WORDS;
            if (!feat_known[fa]) feat_gaps.push_back(fa);
            f = feat_mem[fa];
          end
          acc = acc + f * wgt_mem[wa];
        end
      end
    end
    return acc + bias_mem[ch];
  endfunction

  function automatic job_t random_job(input mcp_op_t kind);
    job_t j;
    j.op    = kind;
    j.addr  = $urandom;
    j.wdata = $urandom;
    j.chan  = $urandom;
    j.row   = $urandom;
    j.col   = $urandom;
    return j;
  endfunction

  // Drive one item, hold until accepted, then update the shadow state
  task automatic issue(input job_t j, input logic typed, input logic [DATA_W-1:0] want);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start    = 1'b0;
      op       = $urandom;
      addr     = $urandom;
      wdata    = $urandom;
      out_chan = $urandom;
      out_row  = $urandom;
      out_col  = $urandom;
      @(negedge clk);
    end
    start    = 1'b1;
    op       = j.op;
    addr     = j.addr;
    wdata    = j.wdata;
    out_chan = j.chan;
    out_row  = j.row;
    out_col  = j.col;
    do @(posedge clk); while (busy);
    case (j.op)
      OP_FEATURE: begin
        feat_mem[j.addr]   = j.wdata;
        feat_known[j.addr] = 1'b1;
      end
      OP_WEIGHT: begin
        wgt_mem[j.addr]   = j.wdata;
        wgt_known[j.addr] = 1'b1;
      end
      OP_BIAS: begin
        bias_mem[j.addr % BIAS_WORDS]   = j.wdata;
        bias_known[j.addr % BIAS_WORDS] = 1'b1;
      end
      default: begin
        // unconfigured channel gives no pixel
        if (j.chan < cfg_out)
          pixels_due.push_back(typed ? want : pixel_value(j.chan, j.row, j.col));
      end
    endcase
  endtask

  // Load random words into every entry the window reads that was never written
  task automatic prime_window(input job_t j);
    logic [DATA_W-1:0] unused_sum;
    job_t fill;
    int unsigned a;
    feat_gaps.delete();
    wgt_gaps.delete();
    unused_sum = pixel_value(j.chan, j.row, j.col);
    while (feat_gaps.size() != 0) begin
      a = feat_gaps.pop_front();
      if (!feat_known[a]) begin
        fill = random_job(OP_FEATURE);
        fill.addr = a;
        issue(fill, 1'b0, '0);
      end
    end
    while (wgt_gaps.size() != 0) begin
      a = wgt_gaps.pop_front();
      if (!wgt_known[a]) begin
        fill = random_job(OP_WEIGHT);
        fill.addr = a;
        issue(fill, 1'b0, '0);
      end
    end
    if (!bias_known[j.chan]) begin
      fill = random_job(OP_BIAS);
      fill.addr = j.chan;
      issue(fill, 1'b0, '0);
    end
  endtask

  // Stop sending, let all pixels come back and the engine go idle
  task automatic wait_quiet(input int tail);
    @(negedge clk);
    start = 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write all eight registers while idle
  task automatic apply_setting(input logic [6:0] v_in, v_out, v_kw, v_kh,
                               input logic [6:0] v_mw, v_mh, v_step, v_pad);
    logic [CFG_DATA_W-1:0] vals [8];
    mcp_reg_t idx;
    int k;
    wait_quiet(SETTLE_CYCLES);
    vals[REG_IN_CHANNELS]   = v_in;
    vals[REG_OUT_CHANNELS]  = v_out;
    vals[REG_KERNEL_WIDTH]  = v_kw;
    vals[REG_KERNEL_HEIGHT] = v_kh;
    vals[REG_MAP_WIDTH]     = v_mw;
    vals[REG_MAP_HEIGHT]    = v_mh;
    vals[REG_STEP_SIZE]     = v_step;
    vals[REG_PAD_AMOUNT]    = v_pad;
    for (k = 0; k < 8; k++) begin
      idx = mcp_reg_t'(k);
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_index = idx;
      cfg_data  = vals[k];
      // registers keep only their own width
      case (idx)
        REG_IN_CHANNELS:   cfg_in   = vals[k][5:0];
        REG_OUT_CHANNELS:  cfg_out  = vals[k][5:0];
        REG_KERNEL_WIDTH:  cfg_kw   = vals[k][3:0];
        REG_KERNEL_HEIGHT: cfg_kh   = vals[k][3:0];
        REG_MAP_WIDTH:     cfg_mw   = vals[k][6:0];
        REG_MAP_HEIGHT:    cfg_mh   = vals[k][6:0];
        REG_STEP_SIZE:     cfg_step = vals[k][3:0];
        default:           cfg_pad  = vals[k][3:0];
      endcase
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Random mix: mostly computes on configured channels near the map
  task automatic run_phase(input int count);
    job_t j;
    int n, roll, eff_out, step_eff, span;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(99) < 3) wait_quiet(SETTLE_CYCLES);
      roll = $urandom_range(99);
      if (roll < 10) j = random_job(OP_FEATURE);
      else if (roll < 20) j = random_job(OP_WEIGHT);
      else if (roll < 28) j = random_job(OP_BIAS);
      else begin
        j = random_job(OP_COMPUTE);
        eff_out = (cfg_out > CHAN_COUNT) ? CHAN_COUNT : cfg_out;
        if (eff_out > 0 && $urandom_range(99) < 85) j.chan = $urandom_range(eff_out - 1);
        step_eff = (cfg_step == 0) ? 1 : cfg_step;
        span = (cfg_mh + 2 * cfg_pad) / step_eff;
        if ($urandom_range(99) < 70) j.row = $urandom_range((span > POS_MAX) ? POS_MAX : span);
        span = (cfg_mw + 2 * cfg_pad) / step_eff;
        if ($urandom_range(99) < 70) j.col = $urandom_range((span > POS_MAX) ? POS_MAX : span);
        if (j.chan < cfg_out) prime_window(j);
      end
      issue(j, 1'b0, '0);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pixels_due.size() == 0) begin
        fails++;
        if (fails <= REPORT_LIMIT)
          $display("unexpected pixel: out_value %h with none pending", out_value);
      end else begin
        want_value = pixels_due.pop_front();
        if (out_value !== want_value) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("out_value mismatch: expected %h, got %h", want_value, out_value);
        end
      end
    end
  end

  // Watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      stall = 0;
    end else begin
      stall++;
      if (stall >= STALL_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
        $display("FAIL multichannel_conv2d_pixel");
        $finish;
      end
    end
  end

  initial begin
    job_t j;
    int k;
    // Directed rows run with a 1x1 kernel on a 2x2 map, two output channels
    probes[0]  = '{OP_FEATURE, 17'h0, 32'd5,          5'd0, 6'd0, 6'd0, 1'b0, 32'h0};
    probes[1]  = '{OP_FEATURE, 17'h1, 32'hFFFF_FFFF,  5'd0, 6'd0, 6'd0, 1'b0, 32'h0};
    probes[2]  = '{OP_FEATURE, 17'h2, 32'h7FFF_FFFF,  5'd0, 6'd0, 6'd0, 1'b0, 32'h0};
    probes[3]  = '{OP_FEATURE, 17'h3, 32'h8000_0000,  5'd0, 6'd0, 6'd0, 1'b0, 32'h0};
    probes[4]  = '{OP_WEIGHT,  17'h0, 32'd3,          5'd0, 6'd0, 6'd0, 1'b0, 32'h0};
    probes[5]  = '{OP_WEIGHT,  17'h1, 32'hFFFF_FFFE,  5'd0, 6'd0, 6'd0, 1'b0, 32'h0};
    probes[6]  = '{OP_BIAS,    17'h0, 32'd100,        5'd0, 6'd0, 6'd0, 1'b0, 32'h0};
    // bias address wraps onto channel 1
    probes[7]  = '{OP_BIAS, 17'h1FFE1, 32'hFFFF_FFF9, 5'd0, 6'd0, 6'd0, 1'b0, 32'h0};
    probes[8]  = '{OP_COMPUTE, 17'h0, 32'h0, 5'd0,  6'd0,  6'd0,  1'b1, 32'd115};
    probes[9]  = '{OP_COMPUTE, 17'h0, 32'h0, 5'd1,  6'd0,  6'd0,  1'b1, 32'hFFFF_FFEF};
    probes[10] = '{OP_COMPUTE, 17'h0, 32'h0, 5'd0,  6'd0,  6'd1,  1'b1, 32'd97};
    // product wraps past 2^32
    probes[11] = '{OP_COMPUTE, 17'h0, 32'h0, 5'd0,  6'd1,  6'd0,  1'b1, 32'h8000_0061};
    probes[12] = '{OP_COMPUTE, 17'h0, 32'h0, 5'd1,  6'd1,  6'd1,  1'b1, 32'hFFFF_FFF9};
    // channels at or above out_channels are dropped
    probes[13] = '{OP_COMPUTE, 17'h0, 32'h0, 5'd2,  6'd0,  6'd0,  1'b0, 32'h0};
    probes[14] = '{OP_COMPUTE, 17'h0, 32'h0, 5'd31, 6'd63, 6'd63, 1'b0, 32'h0};
    // window wholly off the map: bias only
    probes[15] = '{OP_COMPUTE, 17'h0, 32'h0, 5'd0,  6'd63, 6'd63, 1'b1, 32'd100};
    probes[16] = '{OP_WEIGHT,  17'h1FFFF, 32'hDEAD_BEEF, 5'd0, 6'd0, 6'd0, 1'b0, 32'h0};
    probes[17] = '{OP_FEATURE, 17'h1FFFF, 32'h1234_5678, 5'd0, 6'd0, 6'd0, 1'b0, 32'h0};
    probes[18] = '{OP_COMPUTE, 17'h0, 32'h0, 5'd1,  6'd0,  6'd1,  1'b1, 32'hFFFF_FFFB};

    rst       = 1'b1;
    start     = 1'b0;
    op        = OP_FEATURE;
    addr      = '0;
    wdata     = '0;
    out_chan  = '0;
    out_row   = '0;
    out_col   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_IN_CHANNELS;
    cfg_data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part
    apply_setting(7'd1, 7'd2, 7'd1, 7'd1, 7'd2, 7'd2, 7'd1, 7'd0);
    for (k = 0; k < N_PROBES; k++) begin
      j.op    = probes[k].op;
      j.addr  = probes[k].addr;
      j.wdata = probes[k].wdata;
      j.chan  = probes[k].chan;
      j.row   = probes[k].row;
      j.col   = probes[k].col;
      issue(j, probes[k].typed, probes[k].want);
    end

    // Reset defaults
    apply_setting(7'd1, 7'd1, 7'd3, 7'd3, 7'd8, 7'd8, 7'd1, 7'd0);
    run_phase(40);
    // Small multi-channel layer with stride and padding
    apply_setting(7'd2, 7'd3, 7'd2, 7'd3, 7'd5, 7'd6, 7'd2, 7'd1);
    run_phase(35);
    // Smallest legal setting
    apply_setting(7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd0);
    run_phase(15);
    // Largest legal setting
    apply_setting(7'd32, 7'd32, 7'd10, 7'd10, 7'd64, 7'd64, 7'd10, 7'd9);
    run_phase(10);
    // Oversized values saturate, zero stride, feature reads wrap; upper bits ignored
    apply_setting(7'h7F, 7'h7F, 7'h7F, 7'h4C, 7'd127, 7'd127, 7'h70, 7'h25);
    run_phase(12);
    // Empty sums and an empty map: pixel is the bias
    apply_setting(7'h40, 7'd2, 7'd0, 7'd4, 7'd0, 7'd3, 7'd15, 7'd15);
    run_phase(15);
    // Mid-size layer, sender never idles
    apply_setting(7'd3, 7'd4, 7'd4, 7'd2, 7'd12, 7'd9, 7'd3, 7'd2);
    idle_pct = 0;
    run_phase(45);
    idle_pct = IDLE_PCT;

    wait_quiet(DRAIN_CYCLES);
    if (pixels_due.size() != 0) begin
      $display("%0d expected pixels never arrived", pixels_due.size());
      fails += pixels_due.size();
    end
    if (fails == 0) begin
      $display("PASS multichannel_conv2d_pixel");
    end else begin
      $display("FAIL multichannel_conv2d_pixel");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/mcp_pkg.sv
src/mcp_ram.sv
src/mcp_modred.sv
src/multichannel_conv2d_pixel.sv
src/mcp_checker.sv
tb/multichannel_conv2d_pixel_test.sv
